### rtl/gbid_pkg.sv
// Shared types, codes and defaults for the GPIO bank with interrupt detection.
// No dependencies; every other file refers to this package by scoped names or imports it.
package gbid_pkg;

	// Field widths fixed by the bus interface
	localparam int DATA_W        = 32;
	localparam int IDX_W         = 5;
	localparam int CMD_W         = 2;
	localparam int SEL_W         = 3;
	localparam int PIN_COUNT_DEF = 32;
	localparam int OUT_DEPTH     = 2;

	// Commands
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Register map
	localparam logic [SEL_W-1:0] REG_OUT      = 3'd0;
	localparam logic [SEL_W-1:0] REG_IN       = 3'd1;
	localparam logic [SEL_W-1:0] REG_STATUS   = 3'd2;
	localparam logic [SEL_W-1:0] REG_CLEAR    = 3'd3;
	localparam logic [SEL_W-1:0] REG_ENABLE   = 3'd4;
	localparam logic [SEL_W-1:0] REG_EDGE     = 3'd5;
	localparam logic [SEL_W-1:0] REG_POLARITY = 3'd6;
	localparam logic [SEL_W-1:0] REG_OE       = 3'd7;

	// Decoded command broadcast to every pin lane
	typedef struct packed {
		logic acc;
		logic tick;
		logic wr_out;
		logic wr_clear;
		logic wr_en;
		logic wr_edge;
		logic wr_pol;
		logic wr_oe;
	} gbid_ctl_t;

	// Per-pin state after the current beat has been applied
	typedef struct packed {
		logic latch;
		logic oe;
		logic en;
		logic edge_md;
		logic pol;
		logic status;
		logic last;
		logic pend;
	} gbid_lane_t;

	// One result beat
	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic [DATA_W-1:0] drive;
		logic [DATA_W-1:0] drive_en;
		logic              irq;
		logic [IDX_W-1:0]  idx;
	} gbid_res_t;

endpackage

### rtl/gbid_lane.sv
// One pin lane: holds the pin's register bits and runs its interrupt detection.
// Depends on gbid_pkg for the control and lane state structs.
module gbid_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  gbid_pkg::gbid_ctl_t ctl,
	input  logic              wbit,
	input  logic              pin,
	output gbid_pkg::gbid_lane_t nx
);

	logic latch_q, oe_q, en_q, edge_q, pol_q, status_q, last_q;
	logic rise, fall, edge_hit, level_hit;

	// Detect edge events against the previous sample and level events against the polarity
	always_comb begin
		rise      = ~last_q & pin;
		fall      = last_q & ~pin;
		edge_hit  = edge_q & ((pol_q & rise) | (~pol_q & fall));
		level_hit = ~edge_q & ~(pin ^ pol_q);
	end

	// Form the state after this beat
	always_comb begin
		nx.latch   = ctl.wr_out  ? wbit : latch_q;
		nx.oe      = ctl.wr_oe   ? wbit : oe_q;
		nx.en      = ctl.wr_en   ? wbit : en_q;
		nx.edge_md = ctl.wr_edge ? wbit : edge_q;
		nx.pol     = ctl.wr_pol  ? wbit : pol_q;
		nx.last    = ctl.tick    ? pin  : last_q;
		nx.status  = status_q;
		if (ctl.tick) begin
			nx.status = status_q | edge_hit | level_hit;
		end else if (ctl.wr_clear) begin
			nx.status = status_q & ~wbit;
		end
		nx.pend = nx.status & nx.en;
	end

	// Commit on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q  <= 1'b0;
			oe_q     <= 1'b0;
			en_q     <= 1'b0;
			edge_q   <= 1'b0;
			pol_q    <= 1'b0;
			status_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (ctl.acc) begin
			latch_q  <= nx.latch;
			oe_q     <= nx.oe;
			en_q     <= nx.en;
			edge_q   <= nx.edge_md;
			pol_q    <= nx.pol;
			status_q <= nx.status;
			last_q   <= nx.last;
		end
	end

endmodule

### rtl/gbid_merge.sv
// Merge stage: combines the lanes' pending bits into the irq line and the
// lowest pending pin index. Depends on gbid_pkg for the index width.
module gbid_merge #(
	parameter int PIN_COUNT = gbid_pkg::PIN_COUNT_DEF
) (
	input  logic [PIN_COUNT-1:0]        pend,
	output logic                        any,
	output logic [gbid_pkg::IDX_W-1:0]  idx
);

	// Scan from the top so the lowest set bit wins
	always_comb begin
		any = |pend;
		idx = '0;
		for (int i = PIN_COUNT - 1; i >= 0; i--) begin
			if (pend[i]) begin
				idx = gbid_pkg::IDX_W'(i);
			end
		end
	end

endmodule

### rtl/gpio_bank_with_irq_detect_top.sv
// GPIO bank with per-pin edge/level interrupt detection: one pin lane per pin,
// a merge stage and a two-beat output buffer. Depends on gbid_pkg, gbid_lane
// and gbid_merge.
//
// Each input beat (sample tick, register write or register read) is taken
// while in_ready is high, and a new beat can follow in every cycle unless the
// output buffer is full. All pins are handled in parallel lanes, so the cost
// per beat does not depend on PIN_COUNT. The result beat, showing the state
// after the command, is registered into a two-entry output buffer, which keeps
// in_ready high while one result waits; in_ready drops only when two results
// are unclaimed. Pins at or above PIN_COUNT ignore writes and read back as zero.
module gpio_bank_with_irq_detect_top #(
	parameter int PIN_COUNT = gbid_pkg::PIN_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gbid_pkg::CMD_W-1:0]    cmd,
	input  logic [gbid_pkg::SEL_W-1:0]    reg_select,
	input  logic [gbid_pkg::DATA_W-1:0]   write_data,
	input  logic [gbid_pkg::DATA_W-1:0]   pin_levels,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gbid_pkg::DATA_W-1:0]   read_data,
	output logic [gbid_pkg::DATA_W-1:0]   pin_drive,
	output logic [gbid_pkg::DATA_W-1:0]   pin_drive_enable,
	output logic                          irq_line,
	output logic [gbid_pkg::IDX_W-1:0]    first_pending
);

	gbid_pkg::gbid_ctl_t  ctl;
	gbid_pkg::gbid_lane_t lane_nx [PIN_COUNT];
	gbid_pkg::gbid_res_t  res_nx;
	gbid_pkg::gbid_res_t  res_q [gbid_pkg::OUT_DEPTH];

	logic [PIN_COUNT-1:0] v_latch, v_oe, v_en, v_edge, v_pol, v_status, v_last, v_pend;
	logic [PIN_COUNT-1:0] rd_vec;
	logic                 irq_any;
	logic [gbid_pkg::IDX_W-1:0] irq_idx;
	logic [1:0]           cnt_q;
	logic                 wr_ptr_q, rd_ptr_q;
	logic                 push, pop, is_wr;

	// Decode the command for the lanes
	always_comb begin
		push         = in_valid & in_ready;
		is_wr        = (cmd == gbid_pkg::CMD_WRITE);
		ctl.acc      = push;
		ctl.tick     = (cmd == gbid_pkg::CMD_TICK);
		ctl.wr_out   = is_wr && (reg_select == gbid_pkg::REG_OUT);
		ctl.wr_clear = is_wr && (reg_select == gbid_pkg::REG_CLEAR);
		ctl.wr_en    = is_wr && (reg_select == gbid_pkg::REG_ENABLE);
		ctl.wr_edge  = is_wr && (reg_select == gbid_pkg::REG_EDGE);
		ctl.wr_pol   = is_wr && (reg_select == gbid_pkg::REG_POLARITY);
		ctl.wr_oe    = is_wr && (reg_select == gbid_pkg::REG_OE);
	end

	// One lane per pin
	for (genvar p = 0; p < PIN_COUNT; p++) begin : g_lane
		gbid_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wbit   (write_data[p]),
			.pin    (pin_levels[p]),
			.nx     (lane_nx[p])
		);
		assign v_latch[p]  = lane_nx[p].latch;
		assign v_oe[p]     = lane_nx[p].oe;
		assign v_en[p]     = lane_nx[p].en;
		assign v_edge[p]   = lane_nx[p].edge_md;
		assign v_pol[p]    = lane_nx[p].pol;
		assign v_status[p] = lane_nx[p].status;
		assign v_last[p]   = lane_nx[p].last;
		assign v_pend[p]   = lane_nx[p].pend;
	end

	gbid_merge #(.PIN_COUNT(PIN_COUNT)) u_merge (
		.pend (v_pend),
		.any  (irq_any),
		.idx  (irq_idx)
	);

	// Select the register for a read
	always_comb begin
		case (reg_select)
			gbid_pkg::REG_OUT:      rd_vec = v_latch;
			gbid_pkg::REG_IN:       rd_vec = v_last;
			gbid_pkg::REG_STATUS:   rd_vec = v_status;
			gbid_pkg::REG_ENABLE:   rd_vec = v_en;
			gbid_pkg::REG_EDGE:     rd_vec = v_edge;
			gbid_pkg::REG_POLARITY: rd_vec = v_pol;
			gbid_pkg::REG_OE:       rd_vec = v_oe;
			default:                rd_vec = '0;
		endcase
	end

	// Assemble the result beat
	always_comb begin
		res_nx.rdata    = (cmd == gbid_pkg::CMD_READ) ? gbid_pkg::DATA_W'(rd_vec)
		                                              : '0;
		res_nx.drive    = gbid_pkg::DATA_W'(v_latch);
		res_nx.drive_en = gbid_pkg::DATA_W'(v_oe);
		res_nx.irq      = irq_any;
		res_nx.idx      = irq_idx;
	end

	// Output buffer: hold up to two result beats
	assign in_ready  = (cnt_q != 2'(gbid_pkg::OUT_DEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	// Drive the head beat
	always_comb begin
		read_data        = res_q[rd_ptr_q].rdata;
		pin_drive        = res_q[rd_ptr_q].drive;
		pin_drive_enable = res_q[rd_ptr_q].drive_en;
		irq_line         = res_q[rd_ptr_q].irq;
		first_pending    = res_q[rd_ptr_q].idx;
	end

endmodule

### rtl/gbid_checker.sv
// Port-level checks for the GPIO bank, bound to the top level.
// Depends on gbid_pkg and gpio_bank_with_irq_detect_top.
module gbid_port_props #(
	parameter int PIN_COUNT = gbid_pkg::PIN_COUNT_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gbid_pkg::DATA_W-1:0]  read_data,
	input logic [gbid_pkg::DATA_W-1:0]  pin_drive,
	input logic [gbid_pkg::DATA_W-1:0]  pin_drive_enable,
	input logic                         irq_line,
	input logic [gbid_pkg::IDX_W-1:0]   first_pending
);

	// No pending pin means index zero
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !irq_line) |-> (first_pending == '0))
		else $error("first_pending nonzero without irq");

	// Back pressure only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// A result only follows an accepted beat
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without accepted input");

	// Unused pins stay zero
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((read_data | pin_drive | pin_drive_enable) >> PIN_COUNT) == '0))
		else $error("bits beyond PIN_COUNT set");

	// Stalled result stays valid and its read_data holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
		else $error("stalled result changed");

endmodule

bind gpio_bank_with_irq_detect_top gbid_port_props #(.PIN_COUNT(PIN_COUNT)) u_gbid_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.read_data        (read_data),
	.pin_drive        (pin_drive),
	.pin_drive_enable (pin_drive_enable),
	.irq_line         (irq_line),
	.first_pending    (first_pending)
);

### dv/gbid_checker.sv
// Watcher for the GPIO bank: predicts each result beat from the accepted command beats
// and compares the beats that leave the block, field by field, in order.
// Depends on gbid_pkg for widths, command codes and the register map.
module gbid_checker #(
	parameter int PIN_COUNT = gbid_pkg::PIN_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [gbid_pkg::CMD_W-1:0]    cmd,
	input  logic [gbid_pkg::SEL_W-1:0]    reg_select,
	input  logic [gbid_pkg::DATA_W-1:0]   write_data,
	input  logic [gbid_pkg::DATA_W-1:0]   pin_levels,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [gbid_pkg::DATA_W-1:0]   read_data,
	input  logic [gbid_pkg::DATA_W-1:0]   pin_drive,
	input  logic [gbid_pkg::DATA_W-1:0]   pin_drive_enable,
	input  logic                          irq_line,
	input  logic [gbid_pkg::IDX_W-1:0]    first_pending,
	output int                            fail_count,
	output int                            open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import gbid_pkg::*;

	localparam logic [DATA_W-1:0] PIN_MASK = {DATA_W{1'b1}} >> (DATA_W - PIN_COUNT);
	localparam int MAX_REPORTS = 40;

	// Shadow copy of the bank registers
	logic [DATA_W-1:0] drv_latch;
	logic [DATA_W-1:0] drv_oe;
	logic [DATA_W-1:0] irq_en;
	logic [DATA_W-1:0] edge_md;
	logic [DATA_W-1:0] pol;
	logic [DATA_W-1:0] irq_stat;
	logic [DATA_W-1:0] prev_pins;

	gbid_res_t due_beats[$];
	int errs = 0;

	// Apply one command beat to the shadow registers and build the result beat it causes
	function automatic gbid_res_t apply_gpio_beat(
		input logic [CMD_W-1:0]  c,
		input logic [SEL_W-1:0]  s,
		input logic [DATA_W-1:0] wd_in,
		input logic [DATA_W-1:0] pins_in
	);
		logic [DATA_W-1:0] wd;
		logic [DATA_W-1:0] pins;
		logic [DATA_W-1:0] rise;
		logic [DATA_W-1:0] fall;
		logic [DATA_W-1:0] hit;
		logic [DATA_W-1:0] pend;
		gbid_res_t r;
		wd = wd_in & PIN_MASK;
		pins = pins_in & PIN_MASK;
		r = '0;
		case (c)
		CMD_TICK: begin
			// latch edges against the previous sample, levels against polarity
			rise = ~prev_pins & pins;
			fall = prev_pins & ~pins;
			hit = (edge_md & ((pol & rise) | (~pol & fall))) | (~edge_md & ~(pins ^ pol));
			irq_stat = (irq_stat | hit) & PIN_MASK;
			prev_pins = pins;
		end
		CMD_WRITE: begin
			case (s)
			REG_OUT:      drv_latch = wd;
			REG_CLEAR:    irq_stat = irq_stat & ~wd;
			REG_ENABLE:   irq_en = wd;
			REG_EDGE:     edge_md = wd;
			REG_POLARITY: pol = wd;
			REG_OE:       drv_oe = wd;
			default:      ;
			endcase
		end
		CMD_READ: begin
			case (s)
			REG_OUT:      r.rdata = drv_latch;
			REG_IN:       r.rdata = prev_pins;
			REG_STATUS:   r.rdata = irq_stat;
			REG_ENABLE:   r.rdata = irq_en;
			REG_EDGE:     r.rdata = edge_md;
			REG_POLARITY: r.rdata = pol;
			REG_OE:       r.rdata = drv_oe;
			default:      r.rdata = '0;
			endcase
			r.rdata = r.rdata & PIN_MASK;
		end
		default: ;
		endcase
		pend = irq_stat & irq_en & PIN_MASK;
		r.drive = drv_latch & PIN_MASK;
		r.drive_en = drv_oe & PIN_MASK;
		r.irq = |pend;
		// scan downward so the lowest pending pin wins
		r.idx = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (pend[i])
				r.idx = i[IDX_W-1:0];
		end
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		errs++;
		if (errs <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
	endtask

	// Compare the result beat leaving at this edge, then predict the command beat taken
	always @(posedge clk or negedge arst_n) begin : watch
		gbid_res_t want;
		if (!arst_n) begin
			drv_latch = '0;
			drv_oe = '0;
			irq_en = '0;
			edge_md = '0;
			pol = '0;
			irq_stat = '0;
			prev_pins = '0;
			due_beats.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					errs++;
					if (errs <= MAX_REPORTS)
						$display("%0t: result beat with none expected, actual read_data %h",
							$time, read_data);
				end else begin
					want = due_beats.pop_front();
					if (read_data !== want.rdata)
						flag_field("read_data", want.rdata, read_data);
					if (pin_drive !== want.drive)
						flag_field("pin_drive", want.drive, pin_drive);
					if (pin_drive_enable !== want.drive_en)
						flag_field("pin_drive_enable", want.drive_en, pin_drive_enable);
					if (irq_line !== want.irq)
						flag_field("irq_line", DATA_W'(want.irq), DATA_W'(irq_line));
					if (first_pending !== want.idx)
						flag_field("first_pending", DATA_W'(want.idx), DATA_W'(first_pending));
				end
			end
			if (in_valid && in_ready)
				due_beats.push_back(apply_gpio_beat(cmd, reg_select, write_data, pin_levels));
		end
		fail_count <= errs;
		open_count <= due_beats.size();
	end

endmodule

### dv/tb_gpio_bank_with_irq_detect_top.sv
// Top of the GPIO bank testbench: clock, reset, command beats and the result-side stall.
// Depends on gbid_pkg, gpio_bank_with_irq_detect_top and gbid_checker.
module tb_gpio_bank_with_irq_detect_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gbid_pkg::*;

	localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
	localparam int RANDOM_PER_PHASE = 184;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int START_HOLD = 300;
	localparam int HOLD_PERIOD = 3000;
	localparam int HOLD_LEN = 120;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd;
	logic [SEL_W-1:0]  reg_select;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] pin_levels;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] read_data;
	logic [DATA_W-1:0] pin_drive;
	logic [DATA_W-1:0] pin_drive_enable;
	logic              irq_line;
	logic [IDX_W-1:0]  first_pending;
	int                fail_count;
	int                open_count;

	int tx_idle_pct;
	int rx_idle_pct;
	int cycle_count = 0;
	logic [DATA_W-1:0] pins_now = '0;

	gpio_bank_with_irq_detect_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.reg_select       (reg_select),
		.write_data       (write_data),
		.pin_levels       (pin_levels),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_data        (read_data),
		.pin_drive        (pin_drive),
		.pin_drive_enable (pin_drive_enable),
		.irq_line         (irq_line),
		.first_pending    (first_pending)
	);

	gbid_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.reg_select       (reg_select),
		.write_data       (write_data),
		.pin_levels       (pin_levels),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_data        (read_data),
		.pin_drive        (pin_drive),
		.pin_drive_enable (pin_drive_enable),
		.irq_line         (irq_line),
		.first_pending    (first_pending),
		.fail_count       (fail_count),
		.open_count       (open_count)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one command beat, idling first at the sender's rate; return at the accepting edge
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [SEL_W-1:0] s,
			input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] pins);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		reg_select <= s;
		write_data <= wd;
		pin_levels <= pins;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Pick a mix of ticks, writes, reads and idle beats; pins often toggle a single bit to make clean edges
	task automatic random_beat();
		logic [CMD_W-1:0]  c;
		logic [DATA_W-1:0] wd;
		logic [DATA_W-1:0] pins;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			c = CMD_TICK;
		else if (pick < 70)
			c = CMD_WRITE;
		else if (pick < 95)
			c = CMD_READ;
		else
			c = CMD_IDLE;
		case ($urandom_range(9))
		0:       wd = '0;
		1:       wd = '1;
		2:       wd = DATA_W'(1) << $urandom_range(DATA_W - 1);
		default: wd = $urandom;
		endcase
		case ($urandom_range(9))
		0:          pins = '0;
		1:          pins = '1;
		2, 3, 4, 5: pins = pins_now ^ (DATA_W'(1) << $urandom_range(DATA_W - 1));
		default:    pins = $urandom;
		endcase
		if (c == CMD_TICK)
			pins_now = pins;
		send_beat(c, SEL_W'($urandom_range(REG_OE)), wd, pins);
	endtask

	// Result side: long hold-off at start and now and then, random stalls otherwise
	initial begin : result_side
		int hold_left;
		int rx_cycles;
		out_ready = 1'b0;
		hold_left = START_HOLD;
		rx_cycles = 0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
			rx_cycles++;
			if (rx_cycles % HOLD_PERIOD == 0)
				hold_left = HOLD_LEN;
			@(posedge clk);
		end
	end

	// Command side: reset, directed beats, three random phases, drain and verdict
	initial begin : command_side
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		reg_select = REG_OUT;
		write_data = '0;
		pin_levels = '0;
		tx_idle_pct = 31;
		rx_idle_pct = 87;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first tick: low half edge-mode rising against the reset level, high half level-high
		send_beat(CMD_WRITE, REG_EDGE, 32'h0000_FFFF, $urandom);
		send_beat(CMD_WRITE, REG_POLARITY, 32'hFFFF_FFFF, $urandom);
		send_beat(CMD_TICK, REG_STATUS, $urandom, 32'hFFFF_FFFF);
		send_beat(CMD_READ, REG_STATUS, $urandom, $urandom);
		// only the top pin pending, then nothing
		send_beat(CMD_WRITE, REG_ENABLE, 32'h8000_0000, $urandom);
		send_beat(CMD_WRITE, REG_CLEAR, 32'h7FFF_FFFF, $urandom);
		send_beat(CMD_WRITE, REG_CLEAR, 32'hFFFF_FFFF, $urandom);
		// level pins still active latch again after the clear
		send_beat(CMD_TICK, REG_OUT, $urandom, 32'hFFFF_FFFF);
		// all pins falling-edge
		send_beat(CMD_WRITE, REG_POLARITY, 32'h0000_0000, $urandom);
		send_beat(CMD_WRITE, REG_EDGE, 32'hFFFF_FFFF, $urandom);
		send_beat(CMD_WRITE, REG_CLEAR, 32'hFFFF_FFFF, $urandom);
		send_beat(CMD_TICK, REG_OUT, $urandom, 32'hAAAA_AAAA);
		pins_now = 32'hAAAA_AAAA;
		send_beat(CMD_WRITE, REG_ENABLE, 32'hFFFF_FFFF, $urandom);
		send_beat(CMD_WRITE, REG_OUT, 32'hFFFF_FFFF, $urandom);
		send_beat(CMD_WRITE, REG_OE, 32'hFFFF_FFFF, $urandom);
		// read-only registers ignore writes
		send_beat(CMD_WRITE, REG_IN, 32'h1234_5678, $urandom);
		send_beat(CMD_WRITE, REG_STATUS, 32'h0000_0000, $urandom);
		send_beat(CMD_IDLE, REG_EDGE, $urandom, $urandom);
		for (int r = REG_OUT; r <= REG_OE; r++)
			send_beat(CMD_READ, SEL_W'(r), $urandom, $urandom);

		// random phases: slow result side, slow command side, then full rate
		repeat (RANDOM_PER_PHASE) random_beat();
		tx_idle_pct = 87;
		rx_idle_pct = 31;
		repeat (RANDOM_PER_PHASE) random_beat();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (RANDOM_PER_PHASE) random_beat();
		in_valid <= 1'b0;

		// wait out the last result beats
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
